FILE: hdl/tfclr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfclr_pkg
// Shared types, constants and the codon lookup for the three-frame codon
// longest-run block.
// ----------------------------------------------------------------------------
package tfclr_pkg;

    // Sequence capacity and derived widths.
    localparam int MAX_NUCLEOTIDES = 65536;
    localparam int POS_W           = $clog2(MAX_NUCLEOTIDES + 1);
    localparam int NUM_FRAMES      = 3;
    localparam int FRAME_W         = 2;
    localparam int LEN_W           = 15;
    localparam int OFF_W           = 16;
    localparam int BYTE_W          = 8;

    localparam logic [LEN_W-1:0] LEN_SAT      = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] MIN_AA_RESET = LEN_W'(200);

    // Depth of the small register queues.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Characters used by the codon decoder.
    localparam logic [BYTE_W-1:0] CHAR_A       = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_C       = 8'h43;
    localparam logic [BYTE_W-1:0] CHAR_G       = 8'h47;
    localparam logic [BYTE_W-1:0] CHAR_T       = 8'h54;
    localparam logic [BYTE_W-1:0] CHAR_U       = 8'h55;
    localparam logic [BYTE_W-1:0] CHAR_R       = 8'h52;
    localparam logic [BYTE_W-1:0] AA_STOP      = 8'h2A;
    localparam logic [BYTE_W-1:0] AA_UNKNOWN   = 8'h58;

    // Standard genetic code, index = first*16 + second*4 + third with
    // T/U=0, C=1, A=2, G=3. The first character sits in the top byte.
    localparam int CODE_ENTRIES = 64;
    localparam logic [BYTE_W*CODE_ENTRIES-1:0] CODE_TABLE =
        "FFLLSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";

    // Decoded nucleotide.
    typedef struct packed {
        logic       ok;
        logic [1:0] idx;
        logic       is_t;
        logic       is_u;
    } t_nuc;

    // Classified item passed from the front to the back.
    typedef struct packed {
        logic              codon_valid;
        logic [BYTE_W-1:0] amino_acid;
        logic [FRAME_W-1:0] frame;
        logic [OFF_W-1:0]  codon_pos;
        logic              last;
    } t_codon_item;

    // One result item.
    typedef struct packed {
        logic               codon_valid;
        logic [BYTE_W-1:0]  amino_acid;
        logic [FRAME_W-1:0] frame;
        logic               final_res;
        logic               translated;
        logic [OFF_W-1:0]   best_offset;
        logic [LEN_W-1:0]   best_length;
    } t_result;

    // Map one character onto its two-bit nucleotide code.
    function automatic t_nuc nuc_decode(input logic [BYTE_W-1:0] c);
        t_nuc n;
        n = '0;
        case (c)
            CHAR_T: begin n.ok = 1'b1; n.idx = 2'd0; n.is_t = 1'b1; end
            CHAR_U: begin n.ok = 1'b1; n.idx = 2'd0; n.is_u = 1'b1; end
            CHAR_C: begin n.ok = 1'b1; n.idx = 2'd1; end
            CHAR_A: begin n.ok = 1'b1; n.idx = 2'd2; end
            CHAR_G: begin n.ok = 1'b1; n.idx = 2'd3; end
            default: n = '0;
        endcase
        return n;
    endfunction

    // Translate one codon into its amino acid letter.
    function automatic logic [BYTE_W-1:0] lookup_codon(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        t_nuc       na;
        t_nuc       nb;
        t_nuc       nc;
        logic       has_t;
        logic       has_u;
        logic [5:0] idx;
        logic [BYTE_W-1:0] aa;
        na    = nuc_decode(a);
        nb    = nuc_decode(b);
        nc    = nuc_decode(c);
        has_t = na.is_t | nb.is_t | nc.is_t;
        has_u = na.is_u | nb.is_u | nc.is_u;
        idx   = {na.idx, nb.idx, nc.idx};
        if (na.ok && nb.ok && nc.ok && !(has_t && has_u)) begin
            aa = CODE_TABLE[(CODE_ENTRIES - 1 - int'(idx)) * BYTE_W +: BYTE_W];
        end else if ((a == CHAR_T || a == CHAR_U) &&
                     ((b == CHAR_A && c == CHAR_R) || (b == CHAR_R && c == CHAR_A))) begin
            aa = AA_STOP;
        end else begin
            aa = AA_UNKNOWN;
        end
        return aa;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/tfclr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfclr_queue
// Two-entry register queue that decouples the classifying front from the
// run-tracking back.
// ----------------------------------------------------------------------------
module tfclr_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire tfclr_pkg::t_codon_item i_data,
    output      logic                   o_full,
    input  wire logic                   i_pop,
    output      tfclr_pkg::t_codon_item o_data,
    output      logic                   o_empty
);
    import tfclr_pkg::*;

    t_codon_item         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QCNT_W-1:0]   n_count;
    logic                do_push;
    logic                do_pop;

    // Status and read data.
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/tfclr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfclr_front
// Accepts nucleotide bytes, keeps the two previous bytes, and classifies each
// completed codon into its frame and amino acid.
// ----------------------------------------------------------------------------
module tfclr_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic [tfclr_pkg::BYTE_W-1:0]  i_base,
    input  wire logic                          i_last,
    input  wire logic                          i_q_full,
    output      logic                          o_q_push,
    output      tfclr_pkg::t_codon_item        o_item
);
    import tfclr_pkg::*;

    logic [BYTE_W-1:0]  r_prev_one;
    logic [BYTE_W-1:0]  r_prev_two;
    logic [POS_W-1:0]   r_position;
    logic [FRAME_W-1:0] r_frame;
    logic [BYTE_W-1:0]  n_prev_one;
    logic [BYTE_W-1:0]  n_prev_two;
    logic [POS_W-1:0]   n_position;
    logic [FRAME_W-1:0] n_frame;
    logic               accept;
    logic               in_range;
    logic               codon_done;

    // A transfer happens when the queue has room.
    assign accept     = i_push && !i_q_full;
    assign o_q_push   = accept;
    assign in_range   = (r_position < POS_W'(MAX_NUCLEOTIDES));
    assign codon_done = in_range && (r_position >= POS_W'(2));

    // Classify the codon that this byte completes.
    always_comb begin
        o_item             = '0;
        o_item.last        = i_last;
        o_item.codon_valid = codon_done;
        if (codon_done) begin
            o_item.amino_acid = lookup_codon(r_prev_two, r_prev_one, i_base);
            o_item.frame      = r_frame;
            o_item.codon_pos  = OFF_W'(r_position - POS_W'(2));
        end
    end

    // Sequence state advance; the last byte returns it to the start.
    always_comb begin
        n_prev_one = r_prev_one;
        n_prev_two = r_prev_two;
        n_position = r_position;
        n_frame    = r_frame;
        if (accept) begin
            if (i_last) begin
                n_prev_one = '0;
                n_prev_two = '0;
                n_position = '0;
                n_frame    = FRAME_W'(1);
            end else if (in_range) begin
                n_prev_two = r_prev_one;
                n_prev_one = i_base;
                n_position = r_position + 1'b1;
                n_frame    = (r_frame == FRAME_W'(NUM_FRAMES - 1)) ? '0 : r_frame + 1'b1;
            end
        end
    end

    // The frame register holds (position + 1) mod 3, the frame of the next codon.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_one <= '0;
            r_prev_two <= '0;
            r_position <= '0;
            r_frame    <= FRAME_W'(1);
        end else begin
            r_prev_one <= n_prev_one;
            r_prev_two <= n_prev_two;
            r_position <= n_position;
            r_frame    <= n_frame;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/tfclr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfclr_back
// Tracks the current and longest stop-free run of each frame, builds the
// summary on the last item, and holds results in a two-entry output queue.
// ----------------------------------------------------------------------------
module tfclr_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [tfclr_pkg::LEN_W-1:0]   i_min_aa_length,
    input  wire tfclr_pkg::t_codon_item        i_item,
    input  wire logic                          i_q_empty,
    output      logic                          o_q_pop,
    output      tfclr_pkg::t_result            o_result,
    output      logic                          o_empty,
    input  wire logic                          i_pop
);
    import tfclr_pkg::*;

    logic [LEN_W-1:0]   r_run_len   [NUM_FRAMES];
    logic [OFF_W-1:0]   r_run_start [NUM_FRAMES];
    logic [LEN_W-1:0]   r_best_len  [NUM_FRAMES];
    logic [OFF_W-1:0]   r_best_start[NUM_FRAMES];
    logic [LEN_W-1:0]   n_run_len   [NUM_FRAMES];
    logic [OFF_W-1:0]   n_run_start [NUM_FRAMES];
    logic [LEN_W-1:0]   n_best_len  [NUM_FRAMES];
    logic [OFF_W-1:0]   n_best_start[NUM_FRAMES];
    logic [LEN_W-1:0]   inc_len     [NUM_FRAMES];
    logic [FRAME_W-1:0] best_f;
    t_result            result;

    t_result            r_out_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]  n_wr_ptr;
    logic [QPTR_W-1:0]  n_rd_ptr;
    logic [QCNT_W-1:0]  n_count;
    logic               out_full;
    logic               do_step;
    logic               do_out_pop;

    // One item is carried out whenever one waits and the output queue has room.
    assign out_full   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_result   = r_out_mem[r_rd_ptr];
    assign do_step    = !i_q_empty && !out_full;
    assign o_q_pop    = do_step;
    assign do_out_pop = i_pop && !o_empty;

    // Run update for the frame of the completed codon.
    always_comb begin
        for (int f = 0; f < NUM_FRAMES; f++) begin
            inc_len[f]      = (r_run_len[f] < LEN_SAT) ? r_run_len[f] + 1'b1 : r_run_len[f];
            n_run_len[f]    = r_run_len[f];
            n_run_start[f]  = r_run_start[f];
            n_best_len[f]   = r_best_len[f];
            n_best_start[f] = r_best_start[f];
            if (do_step && i_item.codon_valid && (i_item.frame == FRAME_W'(f))) begin
                if (i_item.amino_acid == AA_STOP) begin
                    n_run_len[f]   = '0;
                    n_run_start[f] = i_item.codon_pos + OFF_W'(3);
                end else begin
                    n_run_len[f] = inc_len[f];
                    if (inc_len[f] > r_best_len[f]) begin
                        n_best_len[f]   = inc_len[f];
                        n_best_start[f] = r_run_start[f];
                    end
                end
            end
        end
    end

    // Pick the longest run over all frames; the lowest frame wins a tie.
    always_comb begin
        best_f = '0;
        for (int f = 1; f < NUM_FRAMES; f++) begin
            if (n_best_len[f] > n_best_len[best_f]) begin
                best_f = FRAME_W'(f);
            end
        end
    end

    // Result assembly.
    always_comb begin
        result             = '0;
        result.codon_valid = i_item.codon_valid;
        result.amino_acid  = i_item.amino_acid;
        result.frame       = i_item.frame;
        if (i_item.last) begin
            result.final_res   = 1'b1;
            result.best_length = n_best_len[best_f];
            result.best_offset = n_best_start[best_f];
            result.translated  = (n_best_len[best_f] >= i_min_aa_length);
        end
    end

    // Run state; the last item returns every frame to its start value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < NUM_FRAMES; f++) begin
                r_run_len[f]    <= '0;
                r_run_start[f]  <= OFF_W'(f);
                r_best_len[f]   <= '0;
                r_best_start[f] <= OFF_W'(f);
            end
        end else if (do_step && i_item.last) begin
            for (int f = 0; f < NUM_FRAMES; f++) begin
                r_run_len[f]    <= '0;
                r_run_start[f]  <= OFF_W'(f);
                r_best_len[f]   <= '0;
                r_best_start[f] <= OFF_W'(f);
            end
        end else begin
            r_run_len    <= n_run_len;
            r_run_start  <= n_run_start;
            r_best_len   <= n_best_len;
            r_best_start <= n_best_start;
        end
    end

    // Output queue pointer and count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_step) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_out_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_step && !do_out_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_out_pop && !do_step) begin
            n_count = r_count - 1'b1;
        end
    end

    // Output queue control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Output queue entries.
    always_ff @(posedge i_clk) begin
        if (do_step) begin
            r_out_mem[r_wr_ptr] <= result;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/three_frame_codon_longest_run.sv
`default_nettype none
// A result passes the front-to-back queue and the output queue of the back
// before it can be taken. Throughput: one nucleotide per cycle while no queue
// is full, set by the front's codon lookup and the back's run update.
// Reset clears the sequence state and both queues and sets min_aa_length to
// 200; no clearing pass follows, so the block accepts items right after reset.
// ----------------------------------------------------------------------------
// three_frame_codon_longest_run
// Three-frame codon translation with per-frame longest stop-free run tracking
// and a summary on the final nucleotide of each sequence.
// ----------------------------------------------------------------------------
module three_frame_codon_longest_run (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output      logic                          full,
    input  wire logic [tfclr_pkg::BYTE_W-1:0]  i_base,
    input  wire logic                          i_last,
    output      logic                          empty,
    input  wire logic                          pop,
    output      logic                          o_codon_valid,
    output      logic [tfclr_pkg::BYTE_W-1:0]  o_amino_acid,
    output      logic [tfclr_pkg::FRAME_W-1:0] o_frame,
    output      logic                          o_final_res,
    output      logic                          o_translated,
    output      logic [tfclr_pkg::OFF_W-1:0]   o_best_offset,
    output      logic [tfclr_pkg::LEN_W-1:0]   o_best_length,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [tfclr_pkg::LEN_W-1:0]   i_cfg_wr_data
);
    import tfclr_pkg::*;

    logic [LEN_W-1:0] r_min_aa_length;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    t_codon_item      front_item;
    t_codon_item      back_item;
    t_result          result;

    // Minimum run length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_aa_length <= MIN_AA_RESET;
        end else if (i_cfg_wr_en) begin
            r_min_aa_length <= i_cfg_wr_data;
        end
    end

    // Front: accept and classify.
    tfclr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_base   (i_base),
        .i_last   (i_last),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_item   (front_item)
    );

    // Queue between front and back.
    tfclr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (back_item),
        .o_empty (q_empty)
    );

    // Back: run tracking and result queue.
    tfclr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_min_aa_length (r_min_aa_length),
        .i_item          (back_item),
        .i_q_empty       (q_empty),
        .o_q_pop         (q_pop),
        .o_result        (result),
        .o_empty         (empty),
        .i_pop           (pop)
    );

    // Port fan-out.
    assign full          = q_full;
    assign o_codon_valid = result.codon_valid;
    assign o_amino_acid  = result.amino_acid;
    assign o_frame       = result.frame;
    assign o_final_res   = result.final_res;
    assign o_translated  = result.translated;
    assign o_best_offset = result.best_offset;
    assign o_best_length = result.best_length;

endmodule
`default_nettype wire
